// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on aclk; GBN_ASSERT is held off while aresetn is low, GBN_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define GBN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define GBN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define GBN_ASSERT(lbl, prop, msg)
`define GBN_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, widths and codes shared by the box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int MAX_KEPT_DEF = 256;
    localparam int CORD_W       = 16;
    localparam int AREA_W       = 32;
    localparam int CLS_W        = 7;
    localparam int THR_W        = 9;
    localparam int SLOT_W       = 8;
    localparam int UNI_W        = AREA_W + 1;
    localparam int PROD_W       = UNI_W + CORD_W;
    localparam int THR_RESET    = 128;

    localparam logic CFG_IOU_THRESHOLD  = 1'b0;
    localparam logic CFG_CLASS_AGNOSTIC = 1'b1;

    typedef struct packed {
        logic signed [CORD_W-1:0] bottom;
        logic signed [CORD_W-1:0] right;
        logic signed [CORD_W-1:0] top;
        logic signed [CORD_W-1:0] left;
    } box_t;

    typedef struct packed {
        box_t              box;
        logic [AREA_W-1:0] area;
        logic [CLS_W-1:0]  cls;
    } entry_t;

    typedef struct packed {
        logic load_box;
        logic do_area;
        logic do_span;
        logic do_inter;
        logic do_union;
        logic do_thr;
    } dp_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_SPAN,
        ST_INTER,
        ST_UNION,
        ST_THR,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/gbn_kept_mem.sv =====
// ----------------------------------------------------------------------------
// gbn_kept_mem
// Kept box table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbn_kept_mem
    import gbn_pkg::*;
#(
    parameter int DEPTH = MAX_KEPT_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/gbn_iou_dp.sv =====
// ----------------------------------------------------------------------------
// gbn_iou_dp
// Overlap datapath around one shared multiplier: own area, intersection
// area, union and the threshold product, one step per cycle.
// ----------------------------------------------------------------------------
module gbn_iou_dp
    import gbn_pkg::*;
(
    input  logic             aclk,
    input  dp_ctrl_t         ctrl,
    input  box_t             in_box,
    input  logic [CLS_W-1:0] in_cls,
    input  entry_t           kept,
    input  logic [THR_W-1:0] thr,
    input  logic             agnostic,
    output entry_t           cur,
    output logic             hit
);

    box_t              box_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [AREA_W-1:0] area_reg;
    logic [CORD_W-1:0] iw_reg;
    logic [CORD_W-1:0] ih_reg;
    logic              match_reg;
    logic [AREA_W-1:0] inter_reg;
    logic [UNI_W-1:0]  uni_reg;

    logic signed [CORD_W-1:0] ml, mr, mt, mb;
    logic signed [CORD_W:0]   dx, dy, ow, oh;
    logic [CORD_W-1:0]        iw, ih;
    logic [UNI_W-1:0]         mul_a;
    logic [CORD_W-1:0]        mul_b;
    logic [PROD_W-1:0]        prod;

    always_comb begin
        ml = (box_reg.left > kept.box.left)     ? box_reg.left   : kept.box.left;
        mr = (box_reg.right < kept.box.right)   ? box_reg.right  : kept.box.right;
        mt = (box_reg.top > kept.box.top)       ? box_reg.top    : kept.box.top;
        mb = (box_reg.bottom < kept.box.bottom) ? box_reg.bottom : kept.box.bottom;
        dx = {mr[CORD_W-1], mr} - {ml[CORD_W-1], ml};
        dy = {mb[CORD_W-1], mb} - {mt[CORD_W-1], mt};
        iw = (mr > ml) ? dx[CORD_W-1:0] : '0;
        ih = (mb > mt) ? dy[CORD_W-1:0] : '0;
        ow = {box_reg.right[CORD_W-1], box_reg.right} - {box_reg.left[CORD_W-1], box_reg.left};
        oh = {box_reg.bottom[CORD_W-1], box_reg.bottom} - {box_reg.top[CORD_W-1], box_reg.top};
    end

    always_comb begin
        if (ctrl.do_area) begin
            mul_a = UNI_W'(ow[CORD_W-1:0]);
            mul_b = oh[CORD_W-1:0];
        end else if (ctrl.do_inter) begin
            mul_a = UNI_W'(iw_reg);
            mul_b = ih_reg;
        end else begin
            mul_a = uni_reg;
            mul_b = CORD_W'(thr);
        end
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign hit  = match_reg && (PROD_W'({inter_reg, 8'd0}) > prod);
    assign cur  = '{box: box_reg, area: area_reg, cls: cls_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.load_box) begin
            box_reg.left   <= in_box.left;
            box_reg.top    <= in_box.top;
            box_reg.right  <= (in_box.right < in_box.left) ? in_box.left : in_box.right;
            box_reg.bottom <= (in_box.bottom < in_box.top) ? in_box.top : in_box.bottom;
            cls_reg        <= in_cls;
        end
        if (ctrl.do_area) begin
            area_reg <= prod[AREA_W-1:0];
        end
        if (ctrl.do_span) begin
            iw_reg    <= iw;
            ih_reg    <= ih;
            match_reg <= agnostic || (kept.cls == cls_reg);
        end
        if (ctrl.do_inter) begin
            inter_reg <= prod[AREA_W-1:0];
        end
        if (ctrl.do_union) begin
            uni_reg <= {1'b0, area_reg} + {1'b0, kept.area} - {1'b0, inter_reg};
        end
    end

endmodule

// ===== rtl/core/greedy_box_nms.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over score-sorted boxes.
// ----------------------------------------------------------------------------
// Boxes enter on the s_ stream, one per transfer, corners in signed Q12.4
// and a class label in tdata, the first-box flag in tuser. Each box is
// checked in order against the stored boxes of the current set (same class only
// unless agnostic mode is set) and gets one result on the m_ stream: keep,
// table slot, overflow.
// The scan steps through the table one stored entry at a time on one shared
// multiplier (read, span, intersection, union, threshold) and stops at the
// first suppressing match. s_tready is high only between boxes.
// A result waits in the output register while m_tready is low; the next box
// is accepted and scanned meanwhile, and its result is held back until the
// register frees up.
// Reset empties the table (kept count zero), sets the threshold to 128 and
// clears agnostic mode. Config writes on cfg_wr_en take effect at once and
// belong between boxes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_box_nms
    import gbn_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [THR_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // left[15:0], top[31:16], right[47:32], bottom[63:48], class_label[70:64]
    input  logic [71:0]      s_tdata,
    // first_box[0]
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // keep[0], kept_slot[8:1], overflow[9]
    output logic [15:0]      m_tdata
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              supp_reg, supp_next;
    logic [THR_W-1:0]  thr_reg;
    logic              agn_reg;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;

    dp_ctrl_t          ctrl;
    logic              rd_en, wr_en, out_load;
    logic              s_fire, room, keep, hit;
    box_t              in_box;
    entry_t            kept, cur;

    assign in_box   = '{left: s_tdata[15:0], top: s_tdata[31:16],
                        right: s_tdata[47:32], bottom: s_tdata[63:48]};
    assign s_fire   = s_tvalid && s_tready;
    assign room     = count_reg < CW'(MAX_KEPT);
    assign keep     = !supp_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_AREA;
            ST_AREA:  state_next = ST_SCAN;
            ST_SCAN:  state_next = (supp_reg || idx_reg >= count_reg) ? ST_DONE : ST_SPAN;
            ST_SPAN:  state_next = ST_INTER;
            ST_INTER: state_next = ST_UNION;
            ST_UNION: state_next = ST_THR;
            ST_THR:   state_next = ST_SCAN;
            ST_DONE:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                ctrl.load_box = 1'b1;
            end
            ST_AREA:  ctrl.do_area  = 1'b1;
            ST_SCAN:  rd_en         = !(supp_reg || idx_reg >= count_reg);
            ST_SPAN:  ctrl.do_span  = 1'b1;
            ST_INTER: ctrl.do_inter = 1'b1;
            ST_UNION: ctrl.do_union = 1'b1;
            ST_THR:   ctrl.do_thr   = 1'b1;
            ST_DONE:  out_load      = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
        wr_en = out_load && keep && room;
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        supp_next  = supp_reg;
        if (s_fire && s_tuser) begin
            count_next = '0;
        end
        if (ctrl.do_area) begin
            idx_next  = '0;
            supp_next = 1'b0;
        end
        if (ctrl.do_thr) begin
            idx_next = idx_reg + 1'b1;
            if (hit) begin
                supp_next = 1'b1;
            end
        end
        if (wr_en) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            supp_reg     <= 1'b0;
            thr_reg      <= THR_W'(THR_RESET);
            agn_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            supp_reg  <= supp_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IOU_THRESHOLD:  thr_reg <= cfg_wdata;
                    CFG_CLASS_AGNOSTIC: agn_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'd0, keep && !room,
                            (keep && room) ? SLOT_W'(count_reg) : SLOT_W'(0), keep};
        end
    end

    gbn_kept_mem #(
        .DEPTH (MAX_KEPT)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cur),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (kept)
    );

    gbn_iou_dp u_dp (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .in_box   (in_box),
        .in_cls   (s_tdata[70:64]),
        .kept     (kept),
        .thr      (thr_reg),
        .agnostic (agn_reg),
        .cur      (cur),
        .hit      (hit)
    );

    `GBN_ASSERT(a_count_bound, count_reg <= CW'(MAX_KEPT), "kept count past table depth")
    `GBN_ASSERT(a_scan_in_range, (state_reg == ST_SPAN) |-> (idx_reg < count_reg), "scan index past kept count")
    `GBN_ASSERT(a_write_on_keep, wr_en |-> (!supp_reg && room), "table write for suppressed box or full table")
    `GBN_ASSERT(a_ovf_implies_keep, m_tvalid |-> !(m_tdata[9] && !m_tdata[0]), "overflow without keep")
    `GBN_ASSERT(a_one_step, $onehot0(ctrl), "more than one datapath step at once")

endmodule
